// ===== hw/rtl/mra_pkg.sv =====
package mra_pkg;

  localparam int ROOMS_DEF     = 16;
  localparam int TIME_BITS_DEF = 48;

  localparam logic [6:0]  ROOM_COUNT_RESET = 7'd16;
  localparam logic [31:0] COUNT_MAX        = 32'hFFFF_FFFF;
  localparam logic [47:0] OUT_TIME_MAX     = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_WRITE
  } state_t;

  // Memory port strobes from the sequencer to the room store.
  typedef struct packed {
    logic fin_rd;
    logic use_rd;
    logic wr;
  } mem_ctl_t;

endpackage

// ===== hw/rtl/mra_store.sv =====
module mra_store #(
  parameter int ROOMS     = mra_pkg::ROOMS_DEF,
  parameter int TIME_BITS = mra_pkg::TIME_BITS_DEF,
  localparam int IDX_W    = (ROOMS > 1) ? $clog2(ROOMS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mra_pkg::mem_ctl_t    mem_ctl,
  input  logic [IDX_W-1:0]     fin_rd_addr,
  output logic [TIME_BITS-1:0] fin_rd_data,
  input  logic [IDX_W-1:0]     use_rd_addr,
  output logic [31:0]          use_rd_data,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [TIME_BITS-1:0] wr_fin,
  input  logic [31:0]          wr_uses
);

  logic [TIME_BITS-1:0] fin_mem [ROOMS];
  logic [31:0]          use_mem [ROOMS];
  logic [ROOMS-1:0]     written;
  logic [TIME_BITS-1:0] fin_q;
  logic [31:0]          use_q;
  logic                 fin_ok;
  logic                 use_ok;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr) begin
      fin_mem[wr_addr] <= wr_fin;
      use_mem[wr_addr] <= wr_uses;
    end
    if (mem_ctl.fin_rd) begin
      fin_q <= fin_mem[fin_rd_addr];
    end
    if (mem_ctl.use_rd) begin
      use_q <= use_mem[use_rd_addr];
    end
  end

  // A room that was never written since reset reads as zero: free and unused.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      fin_ok  <= 1'b0;
      use_ok  <= 1'b0;
    end else begin
      if (mem_ctl.wr) begin
        written[wr_addr] <= 1'b1;
      end
      if (mem_ctl.fin_rd) begin
        fin_ok <= written[fin_rd_addr];
      end
      if (mem_ctl.use_rd) begin
        use_ok <= written[use_rd_addr];
      end
    end
  end

  assign fin_rd_data = fin_ok ? fin_q : '0;
  assign use_rd_data = use_ok ? use_q : '0;

endmodule

// ===== hw/rtl/mra_ctrl.sv =====
module mra_ctrl #(
  parameter int ROOMS     = mra_pkg::ROOMS_DEF,
  parameter int TIME_BITS = mra_pkg::TIME_BITS_DEF,
  localparam int IDX_W    = (ROOMS > 1) ? $clog2(ROOMS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [6:0]           cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          start_time,
  input  logic [31:0]          stop_time,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [5:0]           room_index,
  output logic [47:0]          finish_time,
  output logic                 was_delayed,
  output logic [5:0]           top_room,
  output logic [31:0]          top_count,
  output mra_pkg::mem_ctl_t    mem_ctl,
  output logic [IDX_W-1:0]     fin_rd_addr,
  input  logic [TIME_BITS-1:0] fin_rd_data,
  output logic [IDX_W-1:0]     use_rd_addr,
  input  logic [31:0]          use_rd_data,
  output logic [IDX_W-1:0]     wr_addr,
  output logic [TIME_BITS-1:0] wr_fin,
  output logic [31:0]          wr_uses
);

  mra_pkg::state_t state;
  mra_pkg::state_t state_next;

  logic [6:0]           room_count;
  logic [6:0]           rooms_eff;
  logic [31:0]          start_q;
  logic [31:0]          dur_q;
  logic [IDX_W-1:0]     n_last;
  logic [IDX_W-1:0]     iss;
  logic                 iss_done;
  logic                 chk_valid;
  logic [IDX_W-1:0]     chk_idx;
  logic                 found;
  logic [IDX_W-1:0]     free_idx;
  logic [TIME_BITS-1:0] min_f;
  logic [IDX_W-1:0]     min_idx;
  logic [IDX_W-1:0]     pick;
  logic [TIME_BITS-1:0] fin;
  logic                 delayed;
  logic [31:0]          best_count;
  logic [5:0]           best_room;

  logic                 accept;
  logic                 issue;
  logic                 hit;
  logic                 scan_end;
  logic                 out_free;
  logic                 leave_write;
  logic [IDX_W-1:0]     pick_c;
  logic [TIME_BITS-1:0] base;
  logic [TIME_BITS:0]   sum;
  logic [31:0]          uses_new;
  logic                 best_take;
  logic [31:0]          best_count_next;
  logic [5:0]           best_room_next;
  logic [63:0]          fin_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      room_count <= mra_pkg::ROOM_COUNT_RESET;
    end else if (cfg_wr_en) begin
      room_count <= cfg_wr_data;
    end
  end

  assign rooms_eff = (room_count == 7'd0) ? 7'd1 :
                     (room_count > 7'(ROOMS)) ? 7'(ROOMS) : room_count;

  assign accept   = in_valid && !in_stall;
  assign issue    = (state == mra_pkg::ST_SCAN) && !iss_done && !found;
  assign hit      = chk_valid && !found &&
                    (fin_rd_data <= {{(TIME_BITS-32){1'b0}}, start_q});
  assign scan_end = chk_valid && (hit || (chk_idx == n_last));
  assign out_free = !(out_valid && out_stall);
  assign leave_write = (state == mra_pkg::ST_WRITE) && out_free;

  assign pick_c = found ? free_idx : min_idx;
  assign base   = found ? {{(TIME_BITS-32){1'b0}}, start_q} : min_f;
  assign sum    = {1'b0, base} + {{(TIME_BITS-31){1'b0}}, dur_q};

  assign uses_new  = (use_rd_data == mra_pkg::COUNT_MAX) ? use_rd_data : use_rd_data + 32'd1;
  assign best_take = (uses_new > best_count) ||
                     ((uses_new == best_count) && (6'(pick) < best_room));
  assign best_count_next = best_take ? uses_new : best_count;
  assign best_room_next  = best_take ? 6'(pick) : best_room;
  assign fin_w = 64'(fin);

  always_comb begin
    state_next = state;
    case (state)
      mra_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = mra_pkg::ST_SCAN;
        end
      end
      mra_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = mra_pkg::ST_CALC;
        end
      end
      mra_pkg::ST_CALC: begin
        state_next = mra_pkg::ST_WRITE;
      end
      mra_pkg::ST_WRITE: begin
        if (out_free) begin
          state_next = mra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mra_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall       = 1'b1;
    mem_ctl.fin_rd = 1'b0;
    mem_ctl.use_rd = 1'b0;
    mem_ctl.wr     = 1'b0;
    case (state)
      mra_pkg::ST_IDLE: begin
        in_stall = rst;
      end
      mra_pkg::ST_SCAN: begin
        mem_ctl.fin_rd = issue;
      end
      mra_pkg::ST_CALC: begin
        mem_ctl.use_rd = 1'b1;
      end
      mra_pkg::ST_WRITE: begin
        mem_ctl.wr = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign fin_rd_addr = iss;
  assign use_rd_addr = pick_c;
  assign wr_addr     = pick;
  assign wr_fin      = fin;
  assign wr_uses     = uses_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mra_pkg::ST_IDLE;
      chk_valid  <= 1'b0;
      out_valid  <= 1'b0;
      best_count <= '0;
      best_room  <= '0;
    end else begin
      state     <= state_next;
      chk_valid <= issue;
      if (leave_write) begin
        out_valid  <= 1'b1;
        best_count <= best_count_next;
        best_room  <= best_room_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      start_q  <= start_time;
      dur_q    <= (stop_time > start_time) ? stop_time - start_time : 32'd0;
      n_last   <= IDX_W'(rooms_eff - 7'd1);
      iss      <= '0;
      iss_done <= 1'b0;
      found    <= 1'b0;
    end else begin
      if (issue) begin
        iss      <= iss + IDX_W'(1);
        iss_done <= (iss == n_last);
      end
      if (hit) begin
        found    <= 1'b1;
        free_idx <= chk_idx;
      end
    end
    chk_idx <= iss;
    // Earliest finish so far; a strict compare keeps the lowest room on ties.
    if (chk_valid && ((chk_idx == '0) || (fin_rd_data < min_f))) begin
      min_f   <= fin_rd_data;
      min_idx <= chk_idx;
    end
    if (state == mra_pkg::ST_CALC) begin
      pick    <= pick_c;
      delayed <= !found;
      fin     <= sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
    end
    if (leave_write) begin
      room_index  <= 6'(pick);
      finish_time <= (fin_w > 64'(mra_pkg::OUT_TIME_MAX)) ? mra_pkg::OUT_TIME_MAX : fin_w[47:0];
      was_delayed <= delayed;
      top_room    <= best_room_next;
      top_count   <= best_count_next;
    end
  end

endmodule

// ===== hw/rtl/meeting_room_allocator_unit.sv =====
// Channel   Direction  Handshake              Payload
// request   in         in_valid / in_stall    start_time, stop_time
// result    out        out_valid / out_stall  room_index, finish_time, was_delayed,
//                                             top_room, top_count
// config    in         cfg_wr_en              cfg_wr_data (room_count)
//
// A request scans the room finish-time memory one room per cycle until it meets a free
// room or reaches the last room in use, then reads the room's count and writes both back.
// A request is taken only once the one before has been written back. Reset clears all
// rooms at once through per-room written flags. A stalled result holds in the output
// register while the next request is taken; only its write-back waits for the register
// to drain.
module meeting_room_allocator_unit #(
  parameter int ROOMS     = mra_pkg::ROOMS_DEF,
  parameter int TIME_BITS = mra_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] start_time,
  input  logic [31:0] stop_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  room_index,
  output logic [47:0] finish_time,
  output logic        was_delayed,
  output logic [5:0]  top_room,
  output logic [31:0] top_count
);

  localparam int IDX_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;

  mra_pkg::mem_ctl_t    mem_ctl;
  logic [IDX_W-1:0]     fin_rd_addr;
  logic [TIME_BITS-1:0] fin_rd_data;
  logic [IDX_W-1:0]     use_rd_addr;
  logic [31:0]          use_rd_data;
  logic [IDX_W-1:0]     wr_addr;
  logic [TIME_BITS-1:0] wr_fin;
  logic [31:0]          wr_uses;

  mra_ctrl #(
    .ROOMS     (ROOMS),
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .start_time  (start_time),
    .stop_time   (stop_time),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .room_index  (room_index),
    .finish_time (finish_time),
    .was_delayed (was_delayed),
    .top_room    (top_room),
    .top_count   (top_count),
    .mem_ctl     (mem_ctl),
    .fin_rd_addr (fin_rd_addr),
    .fin_rd_data (fin_rd_data),
    .use_rd_addr (use_rd_addr),
    .use_rd_data (use_rd_data),
    .wr_addr     (wr_addr),
    .wr_fin      (wr_fin),
    .wr_uses     (wr_uses)
  );

  mra_store #(
    .ROOMS     (ROOMS),
    .TIME_BITS (TIME_BITS)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .mem_ctl     (mem_ctl),
    .fin_rd_addr (fin_rd_addr),
    .fin_rd_data (fin_rd_data),
    .use_rd_addr (use_rd_addr),
    .use_rd_data (use_rd_data),
    .wr_addr     (wr_addr),
    .wr_fin      (wr_fin),
    .wr_uses     (wr_uses)
  );

`ifndef SYNTHESIS
  // Only one request is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another was in work");

  // The assigned room and the top room are always rooms that exist.
  a_room_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((7'(room_index) < 7'(ROOMS)) && (7'(top_room) < 7'(ROOMS))))
    else $error("room number out of range");

  // Every result follows at least one booking, so the top count cannot be zero.
  a_top_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (top_count != 32'd0))
    else $error("top count zero on a result word");

  // The memory is never written during the room scan.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.fin_rd |-> !mem_ctl.wr)
    else $error("write-back overlaps the room scan");
`endif

endmodule

// ===== bench/room_booking_checker.sv =====
`timescale 1ns / 1ps

module room_booking_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] start_time,
  input  logic [31:0] stop_time,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [5:0]  room_index,
  input  logic [47:0] finish_time,
  input  logic        was_delayed,
  input  logic [5:0]  top_room,
  input  logic [31:0] top_count,
  output int          pending,
  output int          fails,
  output int          delayed_seen,
  output int          saturated_seen
);

  localparam int ROOMS     = mra_pkg::ROOMS_DEF;
  localparam int TIME_BITS = mra_pkg::TIME_BITS_DEF;
  // Written so that a 64-bit time width wraps to all ones instead of shifting out.
  localparam logic [63:0] TIME_CAP = ((64'd1 << (TIME_BITS - 1)) * 64'd2) - 64'd1;

  typedef struct packed {
    logic [5:0]  room;
    logic [47:0] fin;
    logic        late;
    logic [5:0]  lead_room;
    logic [31:0] lead_uses;
  } booking_t;

  logic [63:0] finish_at [ROOMS];
  logic [31:0] uses      [ROOMS];
  logic [31:0] lead_uses;
  logic [5:0]  lead_room;
  logic [6:0]  room_reg;
  booking_t    bookings_due [$];
  int          err_n;
  int          late_n;
  int          cap_n;

  function automatic logic [63:0] add_capped(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] x;
    x = (a > TIME_CAP) ? TIME_CAP : a;
    return (b > TIME_CAP - x) ? TIME_CAP : x + b;
  endfunction

  function automatic booking_t book_room(input logic [31:0] s, input logic [31:0] e);
    int          n;
    int          k;
    int          pick;
    logic        found;
    logic [63:0] dur;
    logic [63:0] fin;
    booking_t    r;
    n = (room_reg == 7'd0) ? 1 : ((int'(room_reg) > ROOMS) ? ROOMS : int'(room_reg));
    dur = (e > s) ? 64'(e - s) : 64'd0;
    found = 1'b0;
    pick = 0;
    for (k = 0; k < n; k++) begin
      if (!found && finish_at[k] <= 64'(s)) begin
        found = 1'b1;
        pick = k;
      end
    end
    if (found) begin
      fin = add_capped(64'(s), dur);
    end else begin
      // Every room is busy: wait for the one that frees first.
      for (k = 1; k < n; k++) begin
        if (finish_at[k] < finish_at[pick]) pick = k;
      end
      fin = add_capped(finish_at[pick], dur);
    end
    finish_at[pick] = fin;
    if (uses[pick] != mra_pkg::COUNT_MAX) uses[pick] = uses[pick] + 32'd1;
    if (uses[pick] > lead_uses || (uses[pick] == lead_uses && pick < int'(lead_room))) begin
      lead_uses = uses[pick];
      lead_room = 6'(pick);
    end
    r.room      = 6'(pick);
    r.fin       = (fin > 64'(mra_pkg::OUT_TIME_MAX)) ? mra_pkg::OUT_TIME_MAX : fin[47:0];
    r.late      = !found;
    r.lead_room = lead_room;
    r.lead_uses = lead_uses;
    return r;
  endfunction

  task automatic report(input string msg);
    err_n++;
    if (err_n <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    booking_t want;
    int       k;
    if (rst) begin
      for (k = 0; k < ROOMS; k++) begin
        finish_at[k] = '0;
        uses[k] = '0;
      end
      lead_uses = '0;
      lead_room = '0;
      room_reg = mra_pkg::ROOM_COUNT_RESET;
      bookings_due.delete();
    end else begin
      if (cfg_wr_en) room_reg = cfg_wr_data;
      if (in_valid && !in_stall) bookings_due.push_back(book_room(start_time, stop_time));
      if (out_valid && !out_stall) begin
        if (was_delayed) late_n++;
        if (finish_time == mra_pkg::OUT_TIME_MAX) cap_n++;
        if (bookings_due.size() == 0) begin
          report($sformatf("result word for room %0d with no request waiting", room_index));
        end else begin
          want = bookings_due.pop_front();
          if (room_index !== want.room)
            report($sformatf("room_index expected %0d, got %0d", want.room, room_index));
          if (finish_time !== want.fin)
            report($sformatf("finish_time expected %0d, got %0d", want.fin, finish_time));
          if (was_delayed !== want.late)
            report($sformatf("was_delayed expected %0d, got %0d", want.late, was_delayed));
          if (top_room !== want.lead_room)
            report($sformatf("top_room expected %0d, got %0d", want.lead_room, top_room));
          if (top_count !== want.lead_uses)
            report($sformatf("top_count expected %0d, got %0d", want.lead_uses, top_count));
        end
      end
    end
    pending        <= bookings_due.size();
    fails          <= err_n;
    delayed_seen   <= late_n;
    saturated_seen <= cap_n;
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 250;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] start_time = '0;
  logic [31:0] stop_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  room_index;
  logic [47:0] finish_time;
  logic        was_delayed;
  logic [5:0]  top_room;
  logic [31:0] top_count;

  int          pending;
  int          fails;
  int          delayed_seen;
  int          saturated_seen;
  int          quiet = 0;
  int          reqs_taken = 0;
  bit          tx_gaps = 1'b0;
  bit          rx_gaps = 1'b0;
  logic [31:0] t_next;

  int phase_rooms [8] = '{1, 0, 127, 17, 64, 5, 16, 3};
  int phase_span  [8] = '{20, 5, 100, 3000, 1 << 20, 40, 7, 200};
  int phase_items [8] = '{70, 50, 80, 70, 70, 80, 80, 80};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  meeting_room_allocator_unit u_top (.*);
  room_booking_checker u_check (.*);

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (!rst && in_valid && !in_stall) reqs_taken <= reqs_taken + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off that lets the
  // block back up into its request channel.
  initial begin
    int burst;
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && reqs_taken >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 11);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic offer_request(input logic [31:0] s, input logic [31:0] e);
    int gap;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    start_time <= s;
    stop_time  <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Wait until every expected result word is back, then give the write-back
  // time to finish.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_rooms(input logic [6:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_phase(input int items, input int span);
    int          k;
    int          pick;
    logic [31:0] s;
    logic [31:0] e;
    for (k = 0; k < items; k++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) t_next = $urandom;
      s = t_next + $urandom_range(0, span);
      if (pick < 16) begin
        e = s + $urandom_range(1, 8 * span);
      end else if (pick < 18) begin
        e = s - $urandom_range(0, span);
      end else begin
        // Noise: arbitrary order and arbitrary end.
        s = $urandom;
        e = $urandom;
      end
      if (pick < 18) t_next = s;
      offer_request(s, e);
    end
  endtask

  initial begin
    int p;
    int k;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;

    // Reset room count, all rooms free.
    offer_request(32'd0, 32'd0);
    for (k = 0; k < 16; k++) offer_request(32'd10, 32'd50);
    offer_request(32'd20, 32'd30);
    offer_request(32'd20, 32'd10);
    offer_request(32'd50, 32'd50);
    offer_request(32'd5, 32'd6);
    offer_request(32'd55, 32'hFFFF_FFFF);
    offer_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_request(32'd0, 32'hFFFF_FFFF);
    offer_request(32'hFFFF_FFFF, 32'd0);
    settle();

    // The third phase and the last phase run with no idling on either side.
    t_next = 32'd100;
    for (p = 0; p < 8; p++) begin
      tx_gaps = (p != 2) && (p != 7);
      rx_gaps = (p != 2) && (p != 7);
      write_rooms((p == 5) ? 7'($urandom_range(2, 15)) : 7'(phase_rooms[p]));
      run_phase(phase_items[p], phase_span[p]);
      settle();
    end

    $display("Ran %0d requests over nine room-count settings.", reqs_taken);
    $display("%0d results waited for a room, %0d hit the finish-time ceiling.",
             delayed_seen, saturated_seen);
    if (fails == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches in total", fails);
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mra_pkg.sv
hw/rtl/mra_store.sv
hw/rtl/mra_ctrl.sv
hw/rtl/meeting_room_allocator_unit.sv
bench/room_booking_checker.sv
bench/tb.sv
